### src/vnts_pkg.sv
// Shared types and character/state codes for the number token scanner.
package vnts_pkg;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_TICK       = 8'h27;
   localparam logic [7:0] CHAR_LOWER_H    = 8'h68;
   localparam logic [7:0] CHAR_LOWER_O    = 8'h6F;
   localparam logic [7:0] CHAR_LOWER_B    = 8'h62;
   localparam logic [7:0] CHAR_LOWER_S    = 8'h73;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_LOWER_E    = 8'h65;
   localparam logic [7:0] CHAR_UPPER_E    = 8'h45;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_ONE        = 8'h31;
   localparam logic [7:0] CHAR_SEVEN      = 8'h37;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;

   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_RADIX     = 3'd1;
   localparam logic [2:0] MODE_DIGITS    = 3'd2;
   localparam logic [2:0] MODE_SIZE      = 3'd3;
   localparam logic [2:0] MODE_FRAC      = 3'd4;
   localparam logic [2:0] MODE_EXP_MARK  = 3'd5;
   localparam logic [2:0] MODE_EXP_MINUS = 3'd6;
   localparam logic [2:0] MODE_EXP_DIG   = 3'd7;

   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_DEC = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   typedef struct packed {
      logic [7:0] current_char;
      logic [7:0] lookahead_char;
      logic       token_start;
   } vnts_req_type;

   typedef struct packed {
      logic in_token;
      logic token_done;
      logic exponent_error;
   } vnts_rsp_type;

   typedef struct packed {
      logic [2:0] scan_mode;
      logic [1:0] radix_kind;
      logic       size_tick_seen;
   } vnts_state_type;

   typedef struct packed {
      logic           take;
      vnts_state_type st;
   } vnts_move_type;

endpackage

### src/vnts_if.sv
// Request and result channel interfaces of the number token scanner.
interface vnts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] current_char;
   logic [7:0] lookahead_char;
   logic       token_start;

   modport source (output valid, output current_char, output lookahead_char,
                   output token_start, input ready);
   modport sink (input valid, input current_char, input lookahead_char,
                 input token_start, output ready);
endinterface

interface vnts_rsp_if;
   logic valid;
   logic ready;
   logic in_token;
   logic token_done;
   logic exponent_error;

   modport source (output valid, output in_token, output token_done,
                   output exponent_error, input ready);
   modport sink (input valid, input in_token, input token_done,
                 input exponent_error, output ready);
endinterface

### src/vnts_step.sv
// Combinational scan step: next scanner state and the result for one character.
module vnts_step import vnts_pkg::*; (
   input  vnts_state_type state,
   input  vnts_req_type   item,
   output vnts_state_type state_next,
   output vnts_rsp_type   result
);

   function automatic logic is_dec(input logic [7:0] ch);
      return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   endfunction

   function automatic logic radix_digit(input logic [7:0] ch, input logic [1:0] radix);
      logic ok;
      ok = 1'b0;
      case (radix)
         RADIX_HEX: ok = is_dec(ch) || ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_F))
                         || ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_F));
         RADIX_DEC: ok = is_dec(ch);
         RADIX_OCT: ok = (ch >= CHAR_ZERO) && (ch <= CHAR_SEVEN);
         default:   ok = (ch == CHAR_ZERO) || (ch == CHAR_ONE);
      endcase
      return ok;
   endfunction

   function automatic logic exp_ok(input logic [7:0] ch, input logic [7:0] la,
                                   input logic [1:0] radix);
      return (radix == RADIX_DEC) && ((ch == CHAR_LOWER_E) || (ch == CHAR_UPPER_E))
             && ((la == CHAR_MINUS) || is_dec(la));
   endfunction

   function automatic vnts_move_type digits_step(input logic [7:0] ch, input logic [7:0] la,
                                                 input vnts_state_type st);
      vnts_move_type mv;
      mv.st = st;
      mv.st.scan_mode = MODE_DIGITS;
      mv.take = 1'b1;
      if ((ch == CHAR_UNDERSCORE) || radix_digit(ch, st.radix_kind)) begin
         mv.take = 1'b1;
      end else if ((ch == CHAR_TICK) && !st.size_tick_seen) begin
         mv.st.size_tick_seen = 1'b1;
         mv.st.scan_mode = MODE_SIZE;
      end else if ((st.radix_kind == RADIX_DEC) && (ch == CHAR_DOT) && is_dec(la)) begin
         mv.st.scan_mode = MODE_FRAC;
      end else if (exp_ok(ch, la, st.radix_kind)) begin
         mv.st.scan_mode = MODE_EXP_MARK;
      end else begin
         mv.take = 1'b0;
      end
      return mv;
   endfunction

   logic [7:0]     ch;
   logic [7:0]     la;
   logic           take;
   logic           done;
   logic           err;
   vnts_state_type base;
   vnts_state_type nxt;
   vnts_move_type  mv;

   assign ch = item.current_char;
   assign la = item.lookahead_char;

   always_comb begin
      take = 1'b0;
      done = 1'b0;
      err  = 1'b0;
      nxt  = state;
      base = state;
      base.radix_kind = RADIX_DEC;
      base.size_tick_seen = 1'b0;
      mv = digits_step(ch, la, state);
      if (item.token_start) begin
         done = (state.scan_mode != MODE_IDLE);
         if ((ch == CHAR_TICK) &&
             ((la == CHAR_LOWER_H) || (la == CHAR_LOWER_O) || (la == CHAR_LOWER_B))) begin
            nxt = base;
            nxt.radix_kind = (la == CHAR_LOWER_H) ? RADIX_HEX :
                             (la == CHAR_LOWER_O) ? RADIX_OCT : RADIX_BIN;
            nxt.scan_mode = MODE_RADIX;
            take = 1'b1;
         end else begin
            mv = digits_step(ch, la, base);
            take = mv.take;
            nxt = mv.st;
            if (!take) begin
               nxt.scan_mode = MODE_IDLE;
            end
         end
      end else if (state.scan_mode != MODE_IDLE) begin
         unique case (state.scan_mode)
            MODE_RADIX: begin
               nxt.scan_mode = MODE_DIGITS;
               take = 1'b1;
            end
            MODE_SIZE: begin
               take = 1'b1;
               if (ch == CHAR_LOWER_S) begin
                  take = 1'b1;
               end else if (ch == CHAR_LOWER_H) begin
                  nxt.radix_kind = RADIX_HEX;
               end else if (ch == CHAR_LOWER_O) begin
                  nxt.radix_kind = RADIX_OCT;
               end else if (ch == CHAR_LOWER_B) begin
                  nxt.radix_kind = RADIX_BIN;
               end else begin
                  take = mv.take;
                  nxt = mv.st;
               end
            end
            MODE_DIGITS: begin
               take = mv.take;
               nxt = mv.st;
            end
            MODE_FRAC: begin
               if (is_dec(ch)) begin
                  take = 1'b1;
               end else if (exp_ok(ch, la, state.radix_kind)) begin
                  nxt.scan_mode = MODE_EXP_MARK;
                  take = 1'b1;
               end
            end
            MODE_EXP_MARK: begin
               if (ch == CHAR_MINUS) begin
                  nxt.scan_mode = MODE_EXP_MINUS;
                  take = 1'b1;
               end else if (is_dec(ch)) begin
                  nxt.scan_mode = MODE_EXP_DIG;
                  take = 1'b1;
               end else begin
                  err = 1'b1;
               end
            end
            MODE_EXP_MINUS: begin
               if (is_dec(ch)) begin
                  nxt.scan_mode = MODE_EXP_DIG;
                  take = 1'b1;
               end else begin
                  err = 1'b1;
               end
            end
            MODE_EXP_DIG: begin
               take = is_dec(ch);
            end
            default: begin
               take = 1'b0;
            end
         endcase
         if (!take) begin
            done = 1'b1;
            nxt.scan_mode = MODE_IDLE;
         end
      end
   end

   assign state_next = nxt;
   assign result = '{in_token: take, token_done: done, exponent_error: err};

endmodule

### src/verilog_number_token_scanner_top.sv
// An accepted request passes the input register, then the result register, to rsp_chan.
// Throughput: one request per cycle; the input register and the result register
// stall together only while a finished result waits on rsp_chan.ready.
// This rate is set by the scan state update, a single short step.
// Reset (synchronous, active high) empties both registers and returns the scanner
// to idle, decimal radix, no size tick seen.
module verilog_number_token_scanner_top import vnts_pkg::*; (
   input logic         clock,
   input logic         reset,
   vnts_req_if.sink    req_chan,
   vnts_rsp_if.source  rsp_chan
);

   // Input register stage holding the character being scanned.
   logic           req_valid_ff;
   logic           req_valid_in;
   vnts_req_type   req_item_ff;

   // Scanner state that carries from one character to the next.
   vnts_state_type state_ff;
   vnts_state_type state_in;

   // Result register facing the consumer.
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   vnts_rsp_type   rsp_item_ff;
   vnts_rsp_type   step_result;

   logic           advance;
   logic           req_take;

   // The result register can take a new value when it is empty or being drained.
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   // The input register frees up whenever its content moves on.
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   vnts_step u_step (
      .state      (state_ff),
      .item       (req_item_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
      end
      if (req_chan.ready) begin
         req_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '{scan_mode: MODE_IDLE, radix_kind: RADIX_DEC, size_tick_seen: 1'b0};
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // The scan state moves exactly when a character leaves the input stage.
         if (req_valid_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers need no reset; they are qualified by the valid flags.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= '{current_char: req_chan.current_char,
                          lookahead_char: req_chan.lookahead_char,
                          token_start: req_chan.token_start};
      end
      if (req_valid_ff && advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.in_token       = rsp_item_ff.in_token;
   assign rsp_chan.token_done     = rsp_item_ff.token_done;
   assign rsp_chan.exponent_error = rsp_item_ff.exponent_error;

endmodule

### src/vnts_checker.sv
// Port-level assertions for the number token scanner and their bind.
module vnts_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_in_token,
   input logic rsp_token_done,
   input logic rsp_exponent_error
);

   logic open_ff;
   logic delivered;

   assign delivered = rsp_valid && rsp_ready;

   // Tracks whether the last delivered result left a token open.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (delivered) begin
         open_ff <= rsp_in_token;
      end
   end

   a_err_ends_token: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_exponent_error) |-> (rsp_token_done && !rsp_in_token))
      else $error("exponent error without a token end");

   a_done_needs_open: assert property (@(posedge clock) disable iff (reset)
      (delivered && rsp_token_done) |-> open_ff)
      else $error("token end reported with no open token");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind verilog_number_token_scanner_top vnts_checker u_vnts_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_in_token       (rsp_chan.in_token),
   .rsp_token_done     (rsp_chan.token_done),
   .rsp_exponent_error (rsp_chan.exponent_error)
);

### tb/tb_top.sv
// Self-checking bench for the number token scanner: directed and random character streams.
module tb_top;
   import vnts_pkg::*;

   logic clock;
   logic reset;

   vnts_req_if req_bus ();
   vnts_rsp_if rsp_bus ();

   verilog_number_token_scanner_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Characters waiting to be offered, and the flags the scanner should report for
   // every request it has taken but not yet answered.
   vnts_req_type char_stream[$];
   vnts_rsp_type expected_flags[$];

   // Scanner state as this bench tracks it, advanced once per accepted request.
   logic [2:0] scan_mode_m;
   logic [1:0] radix_m;
   logic       size_tick_m;

   int  mismatch_count = 0;
   int  accepted_count = 0;
   int  result_count   = 0;
   int  stream_total   = 0;
   bit  req_taken      = 1'b0;
   int  send_gap       = 0;
   int  stall_left     = 0;
   bit  squeeze_done   = 1'b0;

   // ------------------------------------------------------------------------
   // Scanner prediction.
   // ------------------------------------------------------------------------

   function automatic bit is_dec(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   // Whether c is a digit of the radix the current token is using.
   function automatic bit radix_digit(logic [7:0] c);
      case (radix_m)
         RADIX_HEX: return is_dec(c) || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
                           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F);
         RADIX_DEC: return is_dec(c);
         RADIX_OCT: return c >= CHAR_ZERO && c <= CHAR_SEVEN;
         default:   return c == CHAR_ZERO || c == CHAR_ONE;
      endcase
   endfunction

   // An exponent marker only counts in a decimal token when the lookahead
   // promises a minus sign or a digit.
   function automatic bit exponent_opens(logic [7:0] c, logic [7:0] la);
      if (radix_m == RADIX_DEC && (c == CHAR_LOWER_E || c == CHAR_UPPER_E) &&
          (la == CHAR_MINUS || is_dec(la))) begin
         scan_mode_m = MODE_EXP_MARK;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // The digit body of a token: digits, underscores, the one size tick, and the
   // way into a fraction or an exponent.
   function automatic bit digit_body(logic [7:0] c, logic [7:0] la);
      scan_mode_m = MODE_DIGITS;
      if (c == CHAR_UNDERSCORE || radix_digit(c))
         return 1'b1;
      if (c == CHAR_TICK && !size_tick_m) begin
         size_tick_m = 1'b1;
         scan_mode_m = MODE_SIZE;
         return 1'b1;
      end
      if (radix_m == RADIX_DEC && c == CHAR_DOT && is_dec(la)) begin
         scan_mode_m = MODE_FRAC;
         return 1'b1;
      end
      return exponent_opens(c, la);
   endfunction

   // One character of the scan: returns the flags and moves the tracked state on.
   function automatic vnts_rsp_type scan_char(vnts_req_type r);
      vnts_rsp_type f;
      logic [7:0]   c;
      logic [7:0]   la;
      c  = r.current_char;
      la = r.lookahead_char;
      f  = '0;
      if (r.token_start) begin
         f.token_done = (scan_mode_m != MODE_IDLE);
         radix_m      = RADIX_DEC;
         size_tick_m  = 1'b0;
         if (c == CHAR_TICK && (la == CHAR_LOWER_H || la == CHAR_LOWER_O ||
                                la == CHAR_LOWER_B)) begin
            radix_m     = (la == CHAR_LOWER_H) ? RADIX_HEX :
                          (la == CHAR_LOWER_O) ? RADIX_OCT : RADIX_BIN;
            scan_mode_m = MODE_RADIX;
            f.in_token  = 1'b1;
         end else begin
            f.in_token = digit_body(c, la);
            if (!f.in_token)
               scan_mode_m = MODE_IDLE;
         end
      end else if (scan_mode_m != MODE_IDLE) begin
         case (scan_mode_m)
            MODE_RADIX: begin
               scan_mode_m = MODE_DIGITS;
               f.in_token  = 1'b1;
            end
            MODE_SIZE: begin
               if (c == CHAR_LOWER_S) begin
                  f.in_token = 1'b1;
               end else if (c == CHAR_LOWER_H) begin
                  radix_m    = RADIX_HEX;
                  f.in_token = 1'b1;
               end else if (c == CHAR_LOWER_O) begin
                  radix_m    = RADIX_OCT;
                  f.in_token = 1'b1;
               end else if (c == CHAR_LOWER_B) begin
                  radix_m    = RADIX_BIN;
                  f.in_token = 1'b1;
               end else begin
                  f.in_token = digit_body(c, la);
               end
            end
            MODE_DIGITS: f.in_token = digit_body(c, la);
            MODE_FRAC:   f.in_token = is_dec(c) ? 1'b1 : exponent_opens(c, la);
            MODE_EXP_MARK: begin
               if (c == CHAR_MINUS) begin
                  scan_mode_m = MODE_EXP_MINUS;
                  f.in_token  = 1'b1;
               end else if (is_dec(c)) begin
                  scan_mode_m = MODE_EXP_DIG;
                  f.in_token  = 1'b1;
               end else begin
                  f.exponent_error = 1'b1;
               end
            end
            MODE_EXP_MINUS: begin
               if (is_dec(c)) begin
                  scan_mode_m = MODE_EXP_DIG;
                  f.in_token  = 1'b1;
               end else begin
                  f.exponent_error = 1'b1;
               end
            end
            default: f.in_token = is_dec(c);
         endcase
         if (!f.in_token) begin
            f.token_done = 1'b1;
            scan_mode_m  = MODE_IDLE;
         end
      end
      return f;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction.
   // ------------------------------------------------------------------------

   task automatic add_char(logic [7:0] c, logic [7:0] la, logic st);
      vnts_req_type r;
      r.current_char   = c;
      r.lookahead_char = la;
      r.token_start    = st;
      char_stream.push_back(r);
   endtask

   // A legal digit for the radix, now and then an underscore.
   function automatic byte unsigned digit_for(logic [1:0] rk);
      string pool;
      case (rk)
         RADIX_HEX: pool = "0123456789abcdefABCDEF_";
         RADIX_DEC: pool = "0123456789_";
         RADIX_OCT: pool = "01234567_";
         default:   pool = "01_";
      endcase
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   function automatic logic [1:0] random_radix();
      case ($urandom_range(0, 2))
         0:       return RADIX_BIN;
         1:       return RADIX_OCT;
         default: return RADIX_HEX;
      endcase
   endfunction

   function automatic byte unsigned radix_letter(logic [1:0] rk);
      case (rk)
         RADIX_HEX: return CHAR_LOWER_H;
         RADIX_OCT: return CHAR_LOWER_O;
         default:   return CHAR_LOWER_B;
      endcase
   endfunction

   // Builds one mostly well-formed literal (leading-tick based, sized, or real),
   // sometimes plain noise, sometimes broken by a stray character or an extra
   // tick, and queues it with a separator behind it.
   task automatic queue_token();
      byte unsigned lexeme[$];
      byte unsigned sep;
      logic [1:0]   rk;
      int           kind;
      int           n;
      logic [7:0]   la;
      logic         st;
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
         rk = random_radix();
         lexeme.push_back(CHAR_TICK);
         lexeme.push_back(radix_letter(rk));
         n = $urandom_range(1, 8);
         repeat (n) lexeme.push_back(digit_for(rk));
      end else if (kind <= 5) begin
         n = $urandom_range(1, 2);
         repeat (n) lexeme.push_back(digit_for(RADIX_DEC));
         lexeme.push_back(CHAR_TICK);
         if ($urandom_range(0, 2) == 0)
            lexeme.push_back(CHAR_LOWER_S);
         case ($urandom_range(0, 4))
            0: rk = RADIX_DEC;
            1: begin
               lexeme.push_back("d");
               rk = RADIX_DEC;
            end
            default: begin
               rk = random_radix();
               lexeme.push_back(radix_letter(rk));
            end
         endcase
         n = $urandom_range(1, 6);
         repeat (n) lexeme.push_back(digit_for(rk));
      end else if (kind <= 8) begin
         n = $urandom_range(1, 4);
         repeat (n) lexeme.push_back(digit_for(RADIX_DEC));
         if ($urandom_range(0, 1) == 0) begin
            lexeme.push_back(CHAR_DOT);
            n = $urandom_range(1, 3);
            repeat (n) lexeme.push_back(digit_for(RADIX_DEC));
         end
         if ($urandom_range(0, 2) != 0) begin
            lexeme.push_back($urandom_range(0, 1) ? CHAR_LOWER_E : CHAR_UPPER_E);
            if ($urandom_range(0, 1) == 0)
               lexeme.push_back(CHAR_MINUS);
            // No exponent digits at all now and then.
            n = $urandom_range(0, 3);
            repeat (n) lexeme.push_back(digit_for(RADIX_DEC));
         end
      end else begin
         n = $urandom_range(1, 5);
         repeat (n) lexeme.push_back(8'($urandom_range(0, 255)));
      end

      case ($urandom_range(0, 9))
         0: lexeme[$urandom_range(0, lexeme.size() - 1)] = 8'($urandom_range(0, 255));
         1: lexeme.insert($urandom_range(1, lexeme.size()), CHAR_TICK);
         default: ;
      endcase

      case ($urandom_range(0, 4))
         0:       sep = ";";
         1:       sep = ",";
         2:       sep = ")";
         3:       sep = 8'($urandom_range(0, 255));
         default: sep = " ";
      endcase
      lexeme.push_back(sep);

      for (int i = 0; i < lexeme.size(); i++) begin
         la = (i + 1 < lexeme.size()) ? lexeme[i + 1] : 8'($urandom_range(0, 255));
         // A lookahead that lies about the next character is rare but legal.
         if ($urandom_range(0, 19) == 0)
            la = 8'($urandom_range(0, 255));
         if (i == 0)
            st = ($urandom_range(0, 29) != 0);
         else if (i == lexeme.size() - 1)
            st = ($urandom_range(0, 9) == 0);
         else
            st = ($urandom_range(0, 39) == 0);
         add_char(lexeme[i], la, st);
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock, reset, stimulus and end of run.
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      // Known values on every input before the first edge.
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.current_char   = '0;
      req_bus.lookahead_char = '0;
      req_bus.token_start    = 1'b0;
      rsp_bus.ready          = 1'b0;

      // Directed part. A hex literal with a leading tick and an underscore.
      add_char(CHAR_TICK, CHAR_LOWER_H, 1'b1);
      add_char(CHAR_LOWER_H, "F", 1'b0);
      add_char("F", CHAR_UNDERSCORE, 1'b0);
      add_char(CHAR_UNDERSCORE, "8", 1'b0);
      // A start inside that token ends it and opens a sized signed binary
      // literal, which a non-binary digit then ends.
      add_char("8", CHAR_TICK, 1'b1);
      add_char(CHAR_TICK, CHAR_LOWER_S, 1'b0);
      add_char(CHAR_LOWER_S, CHAR_LOWER_B, 1'b0);
      add_char(CHAR_LOWER_B, "1", 1'b0);
      add_char("1", "2", 1'b0);
      add_char("2", "1", 1'b0);
      // A real number with fraction and negative exponent, aborted by a start
      // on a character that cannot open a number.
      add_char("1", CHAR_DOT, 1'b1);
      add_char(CHAR_DOT, "5", 1'b0);
      add_char("5", CHAR_LOWER_E, 1'b0);
      add_char(CHAR_LOWER_E, CHAR_MINUS, 1'b0);
      add_char(CHAR_MINUS, "3", 1'b0);
      add_char("3", "z", 1'b0);
      add_char("z", "7", 1'b1);
      // An exponent marker whose lookahead promised a digit that never came.
      add_char("7", CHAR_UPPER_E, 1'b1);
      add_char(CHAR_UPPER_E, "9", 1'b0);
      add_char("!", 8'h00, 1'b0);
      // Idle characters with extreme codes, with and without a start.
      add_char(8'hFF, 8'h00, 1'b0);
      add_char(8'h00, 8'hFF, 1'b1);
      // A leading tick does not use up the size tick; a second size tick ends
      // the token.
      add_char(CHAR_TICK, CHAR_LOWER_O, 1'b1);
      add_char(CHAR_LOWER_O, CHAR_TICK, 1'b0);
      add_char(CHAR_TICK, CHAR_LOWER_B, 1'b0);
      add_char(CHAR_LOWER_B, "1", 1'b0);
      add_char("1", CHAR_TICK, 1'b0);
      add_char(CHAR_TICK, " ", 1'b0);

      // Random part: a stream of literals and noise.
      while (char_stream.size() < 1730)
         queue_token();
      stream_total = char_stream.size();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Every request offered and taken, then every result back, then a few
      // cycles so that anything extra would still show up.
      while (char_stream.size() != 0 || req_bus.valid)
         @(negedge clock);
      while (expected_flags.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver: presents the next character at the falling edge once the
   // previous one was taken, with short random gaps except near the end.
   // ------------------------------------------------------------------------

   always @(negedge clock) begin : char_driver
      vnts_req_type r;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap      = send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (char_stream.size() != 0) begin
            r = char_stream.pop_front();
            req_bus.current_char   <= r.current_char;
            req_bus.lookahead_char <= r.lookahead_char;
            req_bus.token_start    <= r.token_start;
            req_bus.valid          <= 1'b1;
            if (char_stream.size() > 150 && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 3);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: short random stalls, plus one long hold-off after a few
   // hundred results so that both registers fill and the input stalls.
   // ------------------------------------------------------------------------

   always @(negedge clock) begin : flag_receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left    = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!squeeze_done && result_count >= 400) begin
         squeeze_done  = 1'b1;
         stall_left    = 59;
         rsp_bus.ready <= 1'b0;
      end else if (accepted_count < stream_total - 150 && $urandom_range(0, 6) == 0) begin
         stall_left    = $urandom_range(0, 2);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: at each rising edge, predicts the flags for an accepted request
   // and checks an accepted result against the oldest prediction.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : scan_monitor
      vnts_req_type taken;
      vnts_rsp_type seen;
      vnts_rsp_type want;
      if (reset) begin
         scan_mode_m = MODE_IDLE;
         radix_m     = RADIX_DEC;
         size_tick_m = 1'b0;
         req_taken   = 1'b0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            taken.current_char   = req_bus.current_char;
            taken.lookahead_char = req_bus.lookahead_char;
            taken.token_start    = req_bus.token_start;
            expected_flags.push_back(scan_char(taken));
            accepted_count = accepted_count + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count = result_count + 1;
            seen.in_token       = rsp_bus.in_token;
            seen.token_done     = rsp_bus.token_done;
            seen.exponent_error = rsp_bus.exponent_error;
            if (expected_flags.size() == 0) begin
               $error("result %0d arrived with no request outstanding", result_count);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_flags.pop_front();
               if (seen.in_token !== want.in_token) begin
                  $error("in_token: expected %0d, actual %0d", want.in_token,
                         seen.in_token);
                  mismatch_count = mismatch_count + 1;
               end
               if (seen.token_done !== want.token_done) begin
                  $error("token_done: expected %0d, actual %0d", want.token_done,
                         seen.token_done);
                  mismatch_count = mismatch_count + 1;
               end
               if (seen.exponent_error !== want.exponent_error) begin
                  $error("exponent_error: expected %0d, actual %0d",
                         want.exponent_error, seen.exponent_error);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule
